// File: rtl/core/tts_pkg.sv
// tts_pkg: shared widths, payload structs, register indexes and pipeline depths
// for the time-of-flight trilateration solver; no dependencies
package tts_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int TIME_BITS      = 20;
   localparam int SPEED_BITS     = 20;
   localparam int DEPTH_BITS     = 16;
   localparam int FRAC_BITS      = 16;
   localparam int PROD_T_W       = SPEED_BITS + TIME_BITS;
   localparam int DIST_W         = PROD_T_W + 1 - FRAC_BITS;
   localparam int R2_W           = 2 * DIST_W + 1;
   localparam int B_W            = R2_W + 2;
   localparam int OUT_W          = 24;

   localparam logic [SPEED_BITS-1:0] SPEED_RESET = SPEED_BITS'(96993);
   localparam logic [OUT_W-1:0]      POS_MAX     = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0]      NEG_MAX     = {1'b1, {(OUT_W-1){1'b0}}};

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_SPK1_X = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SPK1_Y = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SPK2_X = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SPK2_Y = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SPK3_X = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SPK3_Y = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_SPEED  = 3'd6;

   localparam int RANGE_LAT = 4;
   localparam int DIV_LAT   = OUT_W + 6;
   localparam int SQRT_LAT  = OUT_W + 3;

   typedef struct packed {
      logic [TIME_BITS-1:0]  time_a;
      logic [TIME_BITS-1:0]  time_b;
      logic [TIME_BITS-1:0]  time_c;
      logic [DEPTH_BITS-1:0] depth_mm;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] pos_x;
      logic signed [OUT_W-1:0] pos_y;
      logic [OUT_W-1:0]        radius;
      logic                    singular;
   } rsp_type;

endpackage

// File: rtl/core/tts_range_lane.sv
// tts_range_lane: one range lane, flight time to squared slant range
// depends on tts_pkg
module tts_range_lane (
   input  logic                             clock,
   input  logic [tts_pkg::TIME_BITS-1:0]    time_us,
   input  logic [tts_pkg::DEPTH_BITS-1:0]   depth,
   input  logic [tts_pkg::SPEED_BITS-1:0]   speed,
   output logic [tts_pkg::R2_W-1:0]         range_sq
);
   logic [tts_pkg::PROD_T_W-1:0]     prod_ff;
   logic [tts_pkg::DEPTH_BITS-1:0]   dep1_ff, dep2_ff;
   logic [tts_pkg::DIST_W-1:0]       dist_ff;
   logic [2*tts_pkg::DIST_W-1:0]     dsq_ff;
   logic [2*tts_pkg::DEPTH_BITS-1:0] zsq_ff;
   logic [tts_pkg::R2_W-1:0]         r2_ff;
   logic [tts_pkg::PROD_T_W:0]       rnd_in;

   // round to nearest mm, ties up
   assign rnd_in = {1'b0, prod_ff} + (tts_pkg::PROD_T_W+1)'(1 << (tts_pkg::FRAC_BITS-1));

   always_ff @(posedge clock) begin
      prod_ff <= speed * time_us;
      dep1_ff <= depth;
      dist_ff <= rnd_in[tts_pkg::PROD_T_W:tts_pkg::FRAC_BITS];
      dep2_ff <= dep1_ff;
      dsq_ff  <= dist_ff * dist_ff;
      zsq_ff  <= dep2_ff * dep2_ff;
      r2_ff   <= tts_pkg::R2_W'(dsq_ff) + tts_pkg::R2_W'(zsq_ff);
   end

   assign range_sq = r2_ff;
endmodule

// File: rtl/core/tts_div_lane.sv
// tts_div_lane: one coordinate lane, cross-product numerator then a pipelined
// restoring divide by twice the determinant with saturation; depends on tts_pkg
module tts_div_lane #(
   parameter int COORD_BITS = tts_pkg::COORD_BITS_DEF
) (
   input  logic                                    clock,
   input  logic signed [tts_pkg::B_W-1:0]          b_p,
   input  logic signed [COORD_BITS:0]              e_q,
   input  logic signed [tts_pkg::B_W-1:0]          b_r,
   input  logic signed [COORD_BITS:0]              e_s,
   input  logic signed [2*(COORD_BITS+1)+1:0]      den,
   output logic signed [tts_pkg::OUT_W-1:0]        quot
);
   localparam int E_W  = COORD_BITS + 1;
   localparam int DW   = 2 * E_W + 2;
   localparam int LO_W = tts_pkg::B_W / 2;
   localparam int HI_W = tts_pkg::B_W - LO_W;
   localparam int PW   = tts_pkg::B_W + E_W;
   localparam int NW   = PW + 1;
   localparam int QW   = tts_pkg::OUT_W;
   localparam int RW   = DW + QW;

   logic signed [HI_W+E_W-1:0]   ph_p_ff, ph_r_ff;
   logic signed [LO_W+E_W:0]     pl_p_ff, pl_r_ff;
   logic signed [PW-1:0]         t_p_ff, t_r_ff;
   logic signed [NW-1:0]         num_ff;
   logic [NW-1:0]                anum_ff;
   logic [DW-1:0]                aden_ff;
   logic                         neg_ff;
   logic [RW-1:0]                rem_ff  [0:QW];
   logic [QW-1:0]                q_ff    [0:QW];
   logic [DW-1:0]                dv_ff   [0:QW];
   logic                         ng_ff   [0:QW];
   logic                         ov_ff   [0:QW];
   logic signed [QW-1:0]         quot_ff;
   logic signed [QW-1:0]         quot_in;
   logic                         ovf_in;

   // partial products keep each multiply near 27 by 17 bits
   always_ff @(posedge clock) begin
      ph_p_ff <= $signed(b_p[tts_pkg::B_W-1:LO_W]) * e_q;
      pl_p_ff <= $signed({1'b0, b_p[LO_W-1:0]}) * e_q;
      ph_r_ff <= $signed(b_r[tts_pkg::B_W-1:LO_W]) * e_s;
      pl_r_ff <= $signed({1'b0, b_r[LO_W-1:0]}) * e_s;
      t_p_ff  <= $signed({ph_p_ff, {LO_W{1'b0}}}) + PW'(pl_p_ff);
      t_r_ff  <= $signed({ph_r_ff, {LO_W{1'b0}}}) + PW'(pl_r_ff);
      num_ff  <= NW'(t_p_ff) - NW'(t_r_ff);
      anum_ff <= num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
      aden_ff <= den[DW-1] ? DW'(-den) : DW'(den);
      neg_ff  <= num_ff[NW-1] ^ den[DW-1];
   end

   // quotient of 2^QW or more always saturates
   assign ovf_in = anum_ff >= NW'({aden_ff, {QW{1'b0}}});

   always_ff @(posedge clock) begin
      rem_ff[0] <= anum_ff[RW-1:0];
      q_ff[0]   <= '0;
      dv_ff[0]  <= aden_ff;
      ng_ff[0]  <= neg_ff;
      ov_ff[0]  <= ovf_in;
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int SH = QW - 1 - k;
      logic [RW-1:0] trial;
      logic          fits;
      assign trial = RW'(dv_ff[k]) << SH;
      assign fits  = rem_ff[k] >= trial;
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= fits ? rem_ff[k] - trial : rem_ff[k];
         q_ff[k+1]   <= {q_ff[k][QW-2:0], fits};
         dv_ff[k+1]  <= dv_ff[k];
         ng_ff[k+1]  <= ng_ff[k];
         ov_ff[k+1]  <= ov_ff[k];
      end
   end

   always_comb begin
      if (ov_ff[QW]) begin
         quot_in = ng_ff[QW] ? tts_pkg::NEG_MAX : tts_pkg::POS_MAX;
      end else if (ng_ff[QW]) begin
         quot_in = (q_ff[QW] > tts_pkg::NEG_MAX) ? tts_pkg::NEG_MAX : QW'(QW'(0) - q_ff[QW]);
      end else begin
         quot_in = (q_ff[QW] > tts_pkg::POS_MAX) ? tts_pkg::POS_MAX : q_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;
endmodule

// File: rtl/core/tts_radius_merge.sv
// tts_radius_merge: merges the two coordinate lanes, floor square root of
// x^2 + y^2 one bit a stage, position carried alongside; depends on tts_pkg
module tts_radius_merge (
   input  logic                              clock,
   input  logic signed [tts_pkg::OUT_W-1:0]  px,
   input  logic signed [tts_pkg::OUT_W-1:0]  py,
   output logic signed [tts_pkg::OUT_W-1:0]  px_out,
   output logic signed [tts_pkg::OUT_W-1:0]  py_out,
   output logic [tts_pkg::OUT_W-1:0]         radius
);
   localparam int W  = tts_pkg::OUT_W;
   localparam int VW = 2 * W;
   localparam int N  = W + 3;

   logic [W-1:0]        ux_ff, uy_ff;
   logic [VW-1:0]       sx_ff, sy_ff;
   logic [VW:0]         rem_ff  [0:W];
   logic [W-1:0]        root_ff [0:W];
   logic signed [W-1:0] px_ff   [0:N-1];
   logic signed [W-1:0] py_ff   [0:N-1];

   always_ff @(posedge clock) begin
      ux_ff      <= px[W-1] ? W'(-px) : W'(px);
      uy_ff      <= py[W-1] ? W'(-py) : W'(py);
      sx_ff      <= ux_ff * ux_ff;
      sy_ff      <= uy_ff * uy_ff;
      rem_ff[0]  <= (VW+1)'(sx_ff) + (VW+1)'(sy_ff);
      root_ff[0] <= '0;
      px_ff[0]   <= px;
      py_ff[0]   <= py;
   end

   for (genvar j = 1; j < N; j++) begin : g_carry
      always_ff @(posedge clock) begin
         px_ff[j] <= px_ff[j-1];
         py_ff[j] <= py_ff[j-1];
      end
   end

   for (genvar k = 0; k < W; k++) begin : g_step
      localparam int B = W - 1 - k;
      logic [VW:0] trial;
      logic        fits;
      // (2*root + 2^b) * 2^b, root holding only bits above b
      assign trial = ((VW+1)'(root_ff[k]) << (B + 1)) + ((VW+1)'(1) << (2 * B));
      assign fits  = rem_ff[k] >= trial;
      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= fits ? rem_ff[k] - trial : rem_ff[k];
         root_ff[k+1] <= fits ? (root_ff[k] | (W'(1) << B)) : root_ff[k];
      end
   end

   assign radius = root_ff[W];
   assign px_out = px_ff[N-1];
   assign py_out = py_ff[N-1];
endmodule

// File: rtl/core/tof_trilateration_solver.sv
// tof_trilateration_solver: top level, register bank, anchor geometry, range
// lanes, coordinate lanes and radius merge; depends on tts_pkg and all tts_ modules
//
//   channel   ports                          direction  handshake
//   request   start, busy, req_item          in         start && !busy
//   result    rsp_valid, rsp_item            out        rsp_valid, one cycle
//   csr       psel penable pwrite paddr ...  in/out     apb, pready high
//
// one request accepted every cycle, busy stays low
// result is registered through 4 range stages, 1 combine stage,
// 30 divide stages (24 quotient bits), 27 square root stages, 1 output register
// the result receiver cannot stall, so nothing holds the pipeline
// synchronous active-high reset clears valid bits and loads register defaults
// anchor geometry is derived from the registers in registered stages, edge vectors first and the determinant last
module tof_trilateration_solver #(
   parameter int COORD_BITS = tts_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  tts_pkg::req_type                   req_item,
   output logic                               rsp_valid,
   output tts_pkg::rsp_type                   rsp_item,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tts_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tts_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tts_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   localparam int C        = COORD_BITS;
   localparam int E_W      = C + 1;
   localparam int SQ_W     = 2 * C;
   localparam int K_W      = 2 * C + 2;
   localparam int PR_W     = 2 * E_W;
   localparam int DW       = 2 * E_W + 2;
   localparam int PIPE_LAT = tts_pkg::RANGE_LAT + 1 + tts_pkg::DIV_LAT + tts_pkg::SQRT_LAT;

   // register bank
   logic [C-1:0]                   x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff;
   logic [tts_pkg::SPEED_BITS-1:0] speed_ff;
   logic                           wr_en;
   logic [tts_pkg::REG_IDX_W-1:0]  widx;

   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign wr_en  = psel && penable && pwrite && pready;
   assign widx   = paddr[tts_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff    <= '0;
         y1_ff    <= '0;
         x2_ff    <= '0;
         y2_ff    <= '0;
         x3_ff    <= '0;
         y3_ff    <= '0;
         speed_ff <= tts_pkg::SPEED_RESET;
      end else if (wr_en) begin
         case (widx)
            tts_pkg::REG_SPK1_X: x1_ff    <= pwdata[C-1:0];
            tts_pkg::REG_SPK1_Y: y1_ff    <= pwdata[C-1:0];
            tts_pkg::REG_SPK2_X: x2_ff    <= pwdata[C-1:0];
            tts_pkg::REG_SPK2_Y: y2_ff    <= pwdata[C-1:0];
            tts_pkg::REG_SPK3_X: x3_ff    <= pwdata[C-1:0];
            tts_pkg::REG_SPK3_Y: y3_ff    <= pwdata[C-1:0];
            tts_pkg::REG_SPEED:  speed_ff <= pwdata[tts_pkg::SPEED_BITS-1:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   always_comb begin
      case (widx)
         tts_pkg::REG_SPK1_X: prdata = tts_pkg::CSR_DATA_W'(x1_ff);
         tts_pkg::REG_SPK1_Y: prdata = tts_pkg::CSR_DATA_W'(y1_ff);
         tts_pkg::REG_SPK2_X: prdata = tts_pkg::CSR_DATA_W'(x2_ff);
         tts_pkg::REG_SPK2_Y: prdata = tts_pkg::CSR_DATA_W'(y2_ff);
         tts_pkg::REG_SPK3_X: prdata = tts_pkg::CSR_DATA_W'(x3_ff);
         tts_pkg::REG_SPK3_Y: prdata = tts_pkg::CSR_DATA_W'(y3_ff);
         tts_pkg::REG_SPEED:  prdata = tts_pkg::CSR_DATA_W'(speed_ff);
         default:             prdata = '0;
      endcase
   end

   // anchor geometry, first stage: edge vectors and squared coordinates
   logic signed [C-1:0]    sx1, sy1, sx2, sy2, sx3, sy3;
   logic signed [E_W-1:0]  e11_ff, e12_ff, e21_ff, e22_ff;
   logic signed [SQ_W-1:0] qx1_ff, qy1_ff, qx2_ff, qy2_ff, qx3_ff, qy3_ff;

   assign sx1 = $signed(x1_ff);
   assign sy1 = $signed(y1_ff);
   assign sx2 = $signed(x2_ff);
   assign sy2 = $signed(y2_ff);
   assign sx3 = $signed(x3_ff);
   assign sy3 = $signed(y3_ff);

   always_ff @(posedge clock) begin
      e11_ff <= E_W'(sx3) - E_W'(sx1);
      e12_ff <= E_W'(sy3) - E_W'(sy1);
      e21_ff <= E_W'(sx3) - E_W'(sx2);
      e22_ff <= E_W'(sy3) - E_W'(sy2);
      qx1_ff <= sx1 * sx1;
      qy1_ff <= sy1 * sy1;
      qx2_ff <= sx2 * sx2;
      qy2_ff <= sy2 * sy2;
      qx3_ff <= sx3 * sx3;
      qy3_ff <= sy3 * sy3;
   end

   // second stage: determinant products and right-hand anchor terms
   logic signed [PR_W-1:0] p11_ff, p12_ff;
   logic signed [K_W-1:0]  k0_ff, k1_ff;

   always_ff @(posedge clock) begin
      p11_ff <= e11_ff * e22_ff;
      p12_ff <= e12_ff * e21_ff;
      k0_ff  <= K_W'(qx1_ff) - K_W'(qx3_ff) + K_W'(qy1_ff) - K_W'(qy3_ff);
      k1_ff  <= K_W'(qx2_ff) - K_W'(qx3_ff) + K_W'(qy2_ff) - K_W'(qy3_ff);
   end

   // third stage: twice the determinant and the collinear flag
   logic signed [DW-2:0] det_in;
   logic signed [DW-1:0] det2_ff;
   logic                 det_zero_ff;

   assign det_in = (DW-1)'(p11_ff) - (DW-1)'(p12_ff);

   always_ff @(posedge clock) begin
      det2_ff     <= $signed({det_in, 1'b0});
      det_zero_ff <= (det_in == '0);
   end

   // three range lanes side by side
   logic [tts_pkg::R2_W-1:0] ra, rb, rc;

   tts_range_lane u_lane_a (
      .clock    (clock),
      .time_us  (req_item.time_a),
      .depth    (req_item.depth_mm),
      .speed    (speed_ff),
      .range_sq (ra)
   );

   tts_range_lane u_lane_b (
      .clock    (clock),
      .time_us  (req_item.time_b),
      .depth    (req_item.depth_mm),
      .speed    (speed_ff),
      .range_sq (rb)
   );

   tts_range_lane u_lane_c (
      .clock    (clock),
      .time_us  (req_item.time_c),
      .depth    (req_item.depth_mm),
      .speed    (speed_ff),
      .range_sq (rc)
   );

   // right-hand side of the 2x2 system
   logic signed [tts_pkg::B_W-1:0] b0_ff, b1_ff;

   always_ff @(posedge clock) begin
      b0_ff <= $signed({2'b00, ra}) - $signed({2'b00, rc}) - tts_pkg::B_W'(k0_ff);
      b1_ff <= $signed({2'b00, rb}) - $signed({2'b00, rc}) - tts_pkg::B_W'(k1_ff);
   end

   // cramer's rule, one lane per coordinate
   logic signed [tts_pkg::OUT_W-1:0] qx, qy;

   tts_div_lane #(.COORD_BITS(COORD_BITS)) u_div_x (
      .clock (clock),
      .b_p   (b0_ff),
      .e_q   (e22_ff),
      .b_r   (b1_ff),
      .e_s   (e12_ff),
      .den   (det2_ff),
      .quot  (qx)
   );

   tts_div_lane #(.COORD_BITS(COORD_BITS)) u_div_y (
      .clock (clock),
      .b_p   (b1_ff),
      .e_q   (e11_ff),
      .b_r   (b0_ff),
      .e_s   (e21_ff),
      .den   (det2_ff),
      .quot  (qy)
   );

   // merge: radius from the saturated position
   logic signed [tts_pkg::OUT_W-1:0] mx, my;
   logic [tts_pkg::OUT_W-1:0]        mr;

   tts_radius_merge u_merge (
      .clock  (clock),
      .px     (qx),
      .py     (qy),
      .px_out (mx),
      .py_out (my),
      .radius (mr)
   );

   // request tracking along the pipeline
   logic [PIPE_LAT-1:0] vld_ff;
   logic                rsp_valid_ff;
   tts_pkg::rsp_type    rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[PIPE_LAT-2:0], start && !busy};
         rsp_valid_ff <= vld_ff[PIPE_LAT-1];
      end
   end

   // collinear anchors force a zero position and radius
   always_ff @(posedge clock) begin
      rsp_ff.pos_x    <= det_zero_ff ? '0 : mx;
      rsp_ff.pos_y    <= det_zero_ff ? '0 : my;
      rsp_ff.radius   <= det_zero_ff ? '0 : mr;
      rsp_ff.singular <= det_zero_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // every accepted request yields its result at the end of the pipeline
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(PIPE_LAT+1) rsp_valid)
      else $error("result missing after fixed latency");

   // a result with no request in flight is invented
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(vld_ff[PIPE_LAT-1]))
      else $error("result without matching request");

   // singular geometry carries a zero position and radius
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.singular) |->
         (rsp_item.pos_x == '0 && rsp_item.pos_y == '0 && rsp_item.radius == '0))
      else $error("singular result with nonzero position");
endmodule
